/* hw/rtl/message_byte_ring_buffer_defines.svh */
// ----------------------------------------------------------------------------
// Message byte ring buffer: assertion macros
// Shared macros for the concurrent checks on the ring buffer ports.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_BYTE_RING_BUFFER_DEFINES_SVH
`define MESSAGE_BYTE_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define MBRB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset.
`define MBRB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mbrb_pkg.sv */
// ----------------------------------------------------------------------------
// Message byte ring buffer package
// Types, codes and constants shared by the ring buffer modules.
// ----------------------------------------------------------------------------
package mbrb_pkg;

	// Default sizes of the ring and of the longest message.
	localparam int CAPACITY_DEF    = 64;
	localparam int MAX_MESSAGE_DEF = 65536;

	// Fixed field widths of the request and result ports.
	localparam int CMD_W     = 3;
	localparam int LEN_W     = 17;
	localparam int BYTE_W    = 8;
	localparam int NPOS_W    = 7;
	localparam int STATUS_W  = 3;
	localparam int CNT_W     = 32;
	localparam int POS_OUT_W = 6;

	// Request commands.
	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE_BEGIN  = 3'd0,
		CMD_WRITE_BYTE   = 3'd1,
		CMD_READ_ALL     = 3'd2,
		CMD_COMMIT_READ  = 3'd3,
		CMD_COMMIT_WRITE = 3'd4,
		CMD_STATS        = 3'd5
	} cmd_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_NOSPACE  = 3'd1,
		ST_INVALID  = 3'd2,
		ST_NOWRITE  = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_DRAIN = 2'd1,
		S_FLUSH = 2'd2
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic drain_begin;
		logic drain_issue;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ring_empty;
		logic issue_last;
	} dp_stat_t;

endpackage

/* hw/rtl/mbrb_ctrl.sv */
// ----------------------------------------------------------------------------
// Message byte ring buffer controller
// Accepts requests and sequences the byte-per-cycle drain of read_all.
// ----------------------------------------------------------------------------
module mbrb_ctrl import mbrb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CMD_W-1:0] cmd,
	input  dp_stat_t         stat,
	output logic             busy,
	output ctl_t             ctl
);

	state_t state_q;
	state_t state_d;
	logic   drain_req;

	// A read_all on a non-empty ring starts a drain.
	assign drain_req = start && (cmd_t'(cmd) == CMD_READ_ALL) && !stat.ring_empty;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (drain_req) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (stat.issue_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs: the last drained byte leaves the read port during the flush state.
	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy            = 1'b0;
				ctl.accept      = start;
				ctl.drain_begin = drain_req;
			end
			S_DRAIN: begin
				ctl.drain_issue = 1'b1;
			end
			S_FLUSH: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

/* hw/rtl/mbrb_datapath.sv */
// ----------------------------------------------------------------------------
// Message byte ring buffer datapath
// Byte store, ring positions, open-write tracking, counters and result register.
// ----------------------------------------------------------------------------
module mbrb_datapath import mbrb_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_t                 ctl,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [LEN_W-1:0]     msg_len,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic [NPOS_W-1:0]    head_set,
	input  logic [NPOS_W-1:0]    tail_set,
	output dp_stat_t             stat,
	output logic                 valid,
	output logic [STATUS_W-1:0]  status,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 last,
	output logic [CNT_W-1:0]     writes_done,
	output logic [CNT_W-1:0]     reads_done,
	output logic [CNT_W-1:0]     writes_failed,
	output logic [POS_OUT_W-1:0] fill_level,
	output logic [POS_OUT_W-1:0] head_pos,
	output logic [POS_OUT_W-1:0] tail_pos
);

	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// Ring positions and open-write state.
	logic [PW-1:0]     head_q;
	logic [PW-1:0]     tail_q;
	logic [PW-1:0]     pend_q;
	logic [PW-1:0]     wcnt_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW-1:0]     rd_left_q;
	logic [CNT_W-1:0]  wr_count_q;
	logic [CNT_W-1:0]  rd_count_q;
	logic [CNT_W-1:0]  fail_count_q;

	// Byte store with per-entry valid bits; an unwritten entry reads as zero.
	logic [BYTE_W-1:0] mem [CAPACITY];
	logic [CAPACITY-1:0] vld_q;
	logic [BYTE_W-1:0] rd_data_q;
	logic              rd_vld_q;

	// Result register.
	logic              res_valid_q;
	logic              res_last_q;
	logic              res_drain_q;
	status_t           res_status_q;

	logic [PW-1:0]     fill;
	logic [PW-1:0]     free_space;
	logic [PW-1:0]     wr_addr;
	logic [PW:0]       wcnt_inc;
	logic              write_done;
	logic              byte_wr_en;

	// Fill level wraps at the ring size; one slot always stays empty.
	assign fill       = tail_q - head_q;
	assign free_space = ~fill;
	assign wr_addr    = tail_q + wcnt_q;
	assign wcnt_inc   = {1'b0, wcnt_q} + (PW + 1)'(1);
	assign write_done = wcnt_inc >= {1'b0, pend_q};
	assign byte_wr_en = ctl.accept && (cmd_t'(cmd) == CMD_WRITE_BYTE) && (pend_q != '0);

	assign stat.ring_empty = (fill == '0);
	assign stat.issue_last = (rd_left_q == '0);

	// Request execution and drain sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			pend_q       <= '0;
			wcnt_q       <= '0;
			rd_ptr_q     <= '0;
			rd_left_q    <= '0;
			wr_count_q   <= '0;
			rd_count_q   <= '0;
			fail_count_q <= '0;
			res_valid_q  <= 1'b0;
			res_last_q   <= 1'b0;
			res_drain_q  <= 1'b0;
			res_status_q <= ST_OK;
		end else if (ctl.accept) begin
			res_valid_q  <= !ctl.drain_begin;
			res_last_q   <= 1'b1;
			res_drain_q  <= 1'b0;
			case (cmd_t'(cmd))
				CMD_WRITE_BEGIN: begin
					// A zero length leaves everything, including an open write, alone.
					if (msg_len == '0) begin
						res_status_q <= ST_OK;
					end else if (msg_len > LEN_W'(MAX_MESSAGE)) begin
						pend_q       <= '0;
						wcnt_q       <= '0;
						fail_count_q <= fail_count_q + CNT_W'(1);
						res_status_q <= ST_INVALID;
					end else if (msg_len > LEN_W'(free_space)) begin
						pend_q       <= '0;
						wcnt_q       <= '0;
						fail_count_q <= fail_count_q + CNT_W'(1);
						res_status_q <= ST_NOSPACE;
					end else begin
						pend_q       <= msg_len[PW-1:0];
						wcnt_q       <= '0;
						res_status_q <= ST_OK;
					end
				end
				CMD_WRITE_BYTE: begin
					if (pend_q == '0) begin
						res_status_q <= ST_NOWRITE;
					end else if (write_done) begin
						// Last byte of the message publishes the tail.
						tail_q       <= wr_addr + PW'(1);
						pend_q       <= '0;
						wcnt_q       <= '0;
						wr_count_q   <= wr_count_q + CNT_W'(1);
						res_status_q <= ST_OK;
					end else begin
						wcnt_q       <= wcnt_q + PW'(1);
						res_status_q <= ST_OK;
					end
				end
				CMD_READ_ALL: begin
					if (ctl.drain_begin) begin
						rd_ptr_q     <= head_q;
						rd_left_q    <= fill - PW'(1);
						head_q       <= tail_q;
						rd_count_q   <= rd_count_q + CNT_W'(1);
						res_status_q <= ST_OK;
					end else begin
						res_status_q <= ST_EMPTY;
					end
				end
				CMD_COMMIT_READ: begin
					if (head_set >= NPOS_W'(CAPACITY)) begin
						res_status_q <= ST_INVALID;
					end else begin
						head_q       <= head_set[PW-1:0];
						res_status_q <= ST_OK;
					end
				end
				CMD_COMMIT_WRITE: begin
					head_q       <= head_set[PW-1:0];
					tail_q       <= tail_set[PW-1:0];
					pend_q       <= '0;
					wcnt_q       <= '0;
					wr_count_q   <= wr_count_q + CNT_W'(1);
					res_status_q <= ST_OK;
				end
				CMD_STATS: begin
					res_status_q <= ST_OK;
				end
				default: begin
					res_status_q <= ST_INVALID;
				end
			endcase
		end else if (ctl.drain_issue) begin
			// One store read per cycle; its data is registered alongside the result and appears with it in the next cycle.
			rd_ptr_q     <= rd_ptr_q + PW'(1);
			rd_left_q    <= rd_left_q - PW'(1);
			res_valid_q  <= 1'b1;
			res_last_q   <= stat.issue_last;
			res_drain_q  <= 1'b1;
			res_status_q <= ST_OK;
		end else begin
			res_valid_q <= 1'b0;
		end
	end

	// Store write and registered read.
	always_ff @(posedge clk) begin
		if (byte_wr_en) begin
			mem[wr_addr] <= data_byte;
		end
		rd_data_q <= mem[rd_ptr_q];
	end

	// Valid bits, cleared at reset, set by each stored byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (byte_wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_ptr_q];
		end
	end

	// Result ports.
	assign valid         = res_valid_q;
	assign status        = res_status_q;
	assign out_byte      = (res_drain_q && rd_vld_q) ? rd_data_q : '0;
	assign last          = res_last_q;
	assign writes_done   = wr_count_q;
	assign reads_done    = rd_count_q;
	assign writes_failed = fail_count_q;
	assign fill_level    = POS_OUT_W'(fill);
	assign head_pos      = POS_OUT_W'(head_q);
	assign tail_pos      = POS_OUT_W'(tail_q);

endmodule

/* hw/rtl/message_byte_ring_buffer.sv */
// ----------------------------------------------------------------------------
// Message byte ring buffer
// Power-of-two circular byte store with message writes and whole-ring drains.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request except
// a drain gives its single result, marked by valid and last, in the cycle after
// it is taken, and the next request can be taken in that same cycle. A read_all
// on a ring holding n bytes keeps busy high through its drain and flush states
// and delivers one byte per cycle; the rate is set by the single read port of
// the byte store, whose output is registered. The receiver cannot stall: each
// result is on the ports for one cycle only.
// Counters and positions in every result are the values after the request.
module message_byte_ring_buffer import mbrb_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [LEN_W-1:0]     msg_len,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic [NPOS_W-1:0]    head_set,
	input  logic [NPOS_W-1:0]    tail_set,
	output logic                 valid,
	output logic [STATUS_W-1:0]  status,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 last,
	output logic [CNT_W-1:0]     writes_done,
	output logic [CNT_W-1:0]     reads_done,
	output logic [CNT_W-1:0]     writes_failed,
	output logic [POS_OUT_W-1:0] fill_level,
	output logic [POS_OUT_W-1:0] head_pos,
	output logic [POS_OUT_W-1:0] tail_pos
);

	ctl_t     ctl;
	dp_stat_t stat;

	// Request sequencing.
	mbrb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Store, positions and counters.
	mbrb_datapath #(
		.CAPACITY    (CAPACITY),
		.MAX_MESSAGE (MAX_MESSAGE)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cmd           (cmd),
		.msg_len       (msg_len),
		.data_byte     (data_byte),
		.head_set      (head_set),
		.tail_set      (tail_set),
		.stat          (stat),
		.valid         (valid),
		.status        (status),
		.out_byte      (out_byte),
		.last          (last),
		.writes_done   (writes_done),
		.reads_done    (reads_done),
		.writes_failed (writes_failed),
		.fill_level    (fill_level),
		.head_pos      (head_pos),
		.tail_pos      (tail_pos)
	);

endmodule

/* hw/rtl/mbrb_checker.sv */
// ----------------------------------------------------------------------------
// Message byte ring buffer checker
// Port-level checks on request acceptance and result sequencing.
// ----------------------------------------------------------------------------
`include "message_byte_ring_buffer_defines.svh"

module mbrb_checker import mbrb_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                valid,
	input logic [STATUS_W-1:0] status,
	input logic [BYTE_W-1:0]   out_byte,
	input logic                last
);

	// A taken request either gives its result next cycle or starts a drain.
	`MBRB_ASSERT_NXT(a_req_answered, start && !busy, valid || busy, "request neither answered nor draining")

	// Drained bytes follow one another without a gap up to the last one.
	`MBRB_ASSERT_NXT(a_drain_contiguous, valid && !last, valid, "gap inside a drain")

	// A drain in progress keeps further requests out.
	`MBRB_ASSERT_IMP(a_drain_busy, valid && !last, busy, "busy low during a drain")

	// Any result other than ok is a lone result with no byte.
	`MBRB_ASSERT_IMP(a_err_single, valid && (status != ST_OK), last && (out_byte == '0), "error result malformed")

endmodule

bind message_byte_ring_buffer mbrb_checker u_mbrb_checker (.*);

/* tb/tb_message_byte_ring_buffer.sv */
// ----------------------------------------------------------------------------
// Message byte ring buffer testbench
// Sends requests through the start/busy handshake and predicts every result
// from a behavioural copy of the ring. Each result is compared field by field
// with the oldest prediction. Directed tests cover the edge cases, then three
// random phases with different amounts of sender idling follow.
// ----------------------------------------------------------------------------
module tb_message_byte_ring_buffer;
	timeunit 1ns;
	timeprecision 1ps;
	import mbrb_pkg::*;

	localparam int RING_SLOTS       = CAPACITY_DEF;
	localparam int WATCHDOG_LIMIT   = 1000;
	localparam int RANDOM_PER_PHASE = 100;

	// Command codes outside the defined set.
	localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

	typedef struct packed {
		status_t               status;
		logic [BYTE_W-1:0]     out_byte;
		logic                  last;
		logic [CNT_W-1:0]      writes_done;
		logic [CNT_W-1:0]      reads_done;
		logic [CNT_W-1:0]      writes_failed;
		logic [POS_OUT_W-1:0]  fill_level;
		logic [POS_OUT_W-1:0]  head_pos;
		logic [POS_OUT_W-1:0]  tail_pos;
	} ring_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [CMD_W-1:0]     cmd = '0;
	logic [LEN_W-1:0]     msg_len = '0;
	logic [BYTE_W-1:0]    data_byte = '0;
	logic [NPOS_W-1:0]    head_set = '0;
	logic [NPOS_W-1:0]    tail_set = '0;
	logic                 valid;
	logic [STATUS_W-1:0]  status;
	logic [BYTE_W-1:0]    out_byte;
	logic                 last;
	logic [CNT_W-1:0]     writes_done;
	logic [CNT_W-1:0]     reads_done;
	logic [CNT_W-1:0]     writes_failed;
	logic [POS_OUT_W-1:0] fill_level;
	logic [POS_OUT_W-1:0] head_pos;
	logic [POS_OUT_W-1:0] tail_pos;

	// Predicted ring contents, positions, open message and counters.
	logic [BYTE_W-1:0]    ring_bytes [RING_SLOTS];
	logic [POS_OUT_W-1:0] ring_head = '0;
	logic [POS_OUT_W-1:0] ring_tail = '0;
	int                   msg_pending = 0;
	int                   msg_written = 0;
	logic [CNT_W-1:0]     write_total = '0;
	logic [CNT_W-1:0]     read_total = '0;
	logic [CNT_W-1:0]     reject_total = '0;
	ring_result_t         expected_results [$];

	int error_count = 0;
	int requests_sent = 0;
	int sender_idle_pct = 0;
	int stalled_cycles = 0;

	message_byte_ring_buffer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.msg_len(msg_len),
		.data_byte(data_byte),
		.head_set(head_set),
		.tail_set(tail_set),
		.valid(valid),
		.status(status),
		.out_byte(out_byte),
		.last(last),
		.writes_done(writes_done),
		.reads_done(reads_done),
		.writes_failed(writes_failed),
		.fill_level(fill_level),
		.head_pos(head_pos),
		.tail_pos(tail_pos)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [POS_OUT_W-1:0] ring_fill();
		return ring_tail - ring_head;
	endfunction

	// Queue one result carrying the counters and positions as they stand now.
	function automatic void expect_result(status_t st, logic [BYTE_W-1:0] b, logic lst);
		ring_result_t r;
		r.status        = st;
		r.out_byte      = b;
		r.last          = lst;
		r.writes_done   = write_total;
		r.reads_done    = read_total;
		r.writes_failed = reject_total;
		r.fill_level    = ring_fill();
		r.head_pos      = ring_head;
		r.tail_pos      = ring_tail;
		expected_results.push_back(r);
	endfunction

	// Update the predicted ring for one accepted request and queue its results.
	function automatic void predict_request(logic [CMD_W-1:0] c, logic [LEN_W-1:0] len,
			logic [BYTE_W-1:0] b, logic [NPOS_W-1:0] nh, logic [NPOS_W-1:0] nt);
		logic [POS_OUT_W-1:0] first;
		logic [POS_OUT_W-1:0] count;
		logic [POS_OUT_W-1:0] slot;
		status_t              st;
		st = ST_OK;
		case (c)
		CMD_WRITE_BEGIN: begin
			// A zero length leaves everything, even an open message, alone.
			if (len != 0) begin
				msg_pending = 0;
				msg_written = 0;
				if (len > MAX_MESSAGE_DEF) begin
					reject_total++;
					st = ST_INVALID;
				end else if (len > RING_SLOTS - 1 - ring_fill()) begin
					reject_total++;
					st = ST_NOSPACE;
				end else begin
					msg_pending = len;
				end
			end
		end
		CMD_WRITE_BYTE: begin
			if (msg_pending == 0) begin
				st = ST_NOWRITE;
			end else begin
				slot = ring_tail + POS_OUT_W'(msg_written);
				ring_bytes[slot] = b;
				msg_written++;
				// The tail moves only once the whole message is in.
				if (msg_written >= msg_pending) begin
					ring_tail = ring_tail + POS_OUT_W'(msg_written);
					msg_pending = 0;
					msg_written = 0;
					write_total++;
				end
			end
		end
		CMD_READ_ALL: begin
			count = ring_fill();
			if (count == 0) begin
				st = ST_EMPTY;
			end else begin
				first = ring_head;
				ring_head = ring_tail;
				read_total++;
				for (int i = 0; i < count; i++)
					expect_result(ST_OK, ring_bytes[first + POS_OUT_W'(i)], i == count - 1);
				return;
			end
		end
		CMD_COMMIT_READ: begin
			if (nh >= RING_SLOTS)
				st = ST_INVALID;
			else
				ring_head = nh[POS_OUT_W-1:0];
		end
		CMD_COMMIT_WRITE: begin
			ring_head = nh[POS_OUT_W-1:0];
			ring_tail = nt[POS_OUT_W-1:0];
			msg_pending = 0;
			msg_written = 0;
			write_total++;
		end
		CMD_STATS: begin
		end
		default: begin
			st = ST_INVALID;
		end
		endcase
		expect_result(st, '0, 1'b1);
	endfunction

	// Drive one request, wait until it is taken, then idle at random.
	task automatic send_request(input logic [CMD_W-1:0] c, input logic [LEN_W-1:0] len,
			input logic [BYTE_W-1:0] b, input logic [NPOS_W-1:0] nh,
			input logic [NPOS_W-1:0] nt);
		start     <= 1'b1;
		cmd       <= c;
		msg_len   <= len;
		data_byte <= b;
		head_set  <= nh;
		tail_set  <= nt;
		do @(posedge clk); while (busy);
		predict_request(c, len, b, nh, nt);
		requests_sent++;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Empty drain, stats, zero-length no-op and a short message drained back.
	task automatic test_write_and_drain();
		send_request(CMD_READ_ALL, '0, '0, '0, '0);
		send_request(CMD_STATS, '0, '0, '0, '0);
		send_request(CMD_WRITE_BEGIN, 17'd0, '0, '0, '0);
		send_request(CMD_WRITE_BEGIN, 17'd3, '0, '0, '0);
		send_request(CMD_WRITE_BYTE, '0, 8'h00, '0, '0);
		send_request(CMD_WRITE_BYTE, '0, 8'hFF, '0, '0);
		send_request(CMD_WRITE_BYTE, '0, 8'hA5, '0, '0);
		send_request(CMD_READ_ALL, '0, '0, '0, '0);
	endtask

	// Over-long and over-full messages, and a begin that drops an open message.
	task automatic test_write_rejects();
		send_request(CMD_WRITE_BEGIN, 17'd65537, '0, '0, '0);
		send_request(CMD_WRITE_BEGIN, 17'h1FFFF, '0, '0, '0);
		send_request(CMD_WRITE_BEGIN, 17'd64, '0, '0, '0);
		send_request(CMD_WRITE_BEGIN, 17'd63, '0, '0, '0);
		send_request(CMD_WRITE_BEGIN, 17'd2, '0, '0, '0);
		send_request(CMD_WRITE_BYTE, '0, 8'h5A, '0, '0);
		send_request(CMD_WRITE_BEGIN, 17'd0, '0, '0, '0);
		send_request(CMD_WRITE_BYTE, '0, 8'hC3, '0, '0);
	endtask

	// A byte with no message open and both undefined command codes.
	task automatic test_stray_and_unknown();
		send_request(CMD_WRITE_BYTE, '0, 8'h77, '0, '0);
		send_request(CMD_UNUSED_6, '1, '1, '1, '1);
		send_request(CMD_UNUSED_7, '1, '1, '1, '1);
	endtask

	// Position commits: a head move inside an open message, an out-of-range
	// head, masked commits and a drain of a completely full ring.
	task automatic test_commits();
		send_request(CMD_WRITE_BEGIN, 17'd2, '0, '0, '0);
		send_request(CMD_WRITE_BYTE, '0, 8'h11, '0, '0);
		send_request(CMD_COMMIT_READ, '0, '0, 7'd1, '0);
		send_request(CMD_WRITE_BYTE, '0, 8'hEE, '0, '0);
		send_request(CMD_COMMIT_READ, '0, '0, 7'd127, '0);
		send_request(CMD_COMMIT_WRITE, '0, '0, 7'd127, 7'd0);
		send_request(CMD_COMMIT_WRITE, '0, '0, 7'd0, 7'd127);
		send_request(CMD_READ_ALL, '0, '0, '0, '0);
	endtask

	// Mostly complete messages with random content, mixed with drains,
	// commits, stats, cut-short messages and fully random requests.
	task automatic test_random_traffic(input int idle_pct);
		int stop_at;
		int free_slots;
		int len;
		int kind;
		int sent_bytes;
		stop_at = requests_sent + RANDOM_PER_PHASE;
		sender_idle_pct = idle_pct;
		while (requests_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			free_slots = RING_SLOTS - 1 - ring_fill();
			if (kind < 55 && free_slots > 0) begin
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(1, free_slots);
				else
					len = $urandom_range(1, (free_slots < 8) ? free_slots : 8);
				if ($urandom_range(0, 9) == 0)
					sent_bytes = $urandom_range(0, len - 1);
				else
					sent_bytes = len;
				send_request(CMD_WRITE_BEGIN, LEN_W'(len), BYTE_W'($urandom),
					NPOS_W'($urandom), NPOS_W'($urandom));
				repeat (sent_bytes)
					send_request(CMD_WRITE_BYTE, LEN_W'($urandom), BYTE_W'($urandom),
						NPOS_W'($urandom), NPOS_W'($urandom));
			end else if (kind < 72) begin
				send_request(CMD_READ_ALL, LEN_W'($urandom), BYTE_W'($urandom),
					NPOS_W'($urandom), NPOS_W'($urandom));
			end else if (kind < 78) begin
				send_request(CMD_STATS, LEN_W'($urandom), BYTE_W'($urandom),
					NPOS_W'($urandom), NPOS_W'($urandom));
			end else if (kind < 84) begin
				send_request(CMD_COMMIT_READ, LEN_W'($urandom), BYTE_W'($urandom),
					NPOS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
						: $urandom_range(0, RING_SLOTS - 1)),
					NPOS_W'($urandom));
			end else if (kind < 88) begin
				send_request(CMD_COMMIT_WRITE, LEN_W'($urandom), BYTE_W'($urandom),
					NPOS_W'($urandom), NPOS_W'($urandom));
			end else begin
				send_request(CMD_W'($urandom_range(0, 7)),
					LEN_W'($urandom_range(0, 1) ? $urandom_range(0, 131071)
						: $urandom_range(0, 70)),
					BYTE_W'($urandom), NPOS_W'($urandom), NPOS_W'($urandom));
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= 10)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Check every result against the oldest prediction.
	always @(posedge clk) begin : check_results
		ring_result_t want;
		if (arst_n && valid) begin
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: result with no request outstanding", $time);
			end else begin
				want = expected_results.pop_front();
				compare_field("status", CNT_W'(want.status), CNT_W'(status));
				compare_field("out_byte", CNT_W'(want.out_byte), CNT_W'(out_byte));
				compare_field("last", CNT_W'(want.last), CNT_W'(last));
				compare_field("writes_done", want.writes_done, writes_done);
				compare_field("reads_done", want.reads_done, reads_done);
				compare_field("writes_failed", want.writes_failed, writes_failed);
				compare_field("fill_level", CNT_W'(want.fill_level), CNT_W'(fill_level));
				compare_field("head_pos", CNT_W'(want.head_pos), CNT_W'(head_pos));
				compare_field("tail_pos", CNT_W'(want.tail_pos), CNT_W'(tail_pos));
			end
		end
	end

	// Watchdog: end the run if neither a request nor a result moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || valid)
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		foreach (ring_bytes[i])
			ring_bytes[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_write_and_drain();
		test_write_rejects();
		test_stray_and_unknown();
		test_commits();
		test_random_traffic(0);
		test_random_traffic(82);
		test_random_traffic(35);
		start <= 1'b0;

		// Let the outstanding results drain, then allow for stray ones.
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mbrb_pkg.sv
hw/rtl/mbrb_ctrl.sv
hw/rtl/mbrb_datapath.sv
hw/rtl/message_byte_ring_buffer.sv
hw/rtl/mbrb_checker.sv
tb/tb_message_byte_ring_buffer.sv
